@@ hdl/sidc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_pkg - shared types and constants of the sorted id set block
// Sizes, beat payload structs, command codes and the link types that
// connect neighboring cells of the set chain.
// ----------------------------------------------------------------------------
package sidc_pkg;

    localparam int SET_DEPTH = 64;
    localparam int ID_BITS   = 16;

    localparam int ITEM_ID_W = 16;
    localparam int COUNT_W   = 7;
    localparam int LIMIT_W   = 7;
    localparam int FILL_W    = $clog2(SET_DEPTH + 1);
    localparam int CMP_W     = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(64);
    localparam logic [CMP_W-1:0]   DEPTH_CMP  = CMP_W'(SET_DEPTH);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                 command;
        logic [ITEM_ID_W-1:0] item_id;
        logic                 last_of_pattern;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               pattern_done;
        logic               set_full;
        logic               insert_dropped;
    } t_out_beat;

    // Broadcast from the control logic to every cell
    typedef struct packed {
        logic               ins_en;
        logic               qry_en;
        logic               cur_clr;
        logic [ID_BITS-1:0] key;
    } t_bcast;

    // What a cell shows its right-hand neighbor
    typedef struct packed {
        logic               valid;
        logic               take;
        logic               cur_next;
        logic [ID_BITS-1:0] id;
    } t_link;

    function automatic logic [ID_BITS-1:0] id_of(input logic [ITEM_ID_W-1:0] raw);
        logic [ID_BITS+ITEM_ID_W-1:0] ext;
        ext = {{ID_BITS{1'b0}}, raw};
        return ext[ID_BITS-1:0];
    endfunction

endpackage

@@ hdl/sorted_id_set_intersection_count_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_set_intersection_count_top - sorted id set with pattern match count
// Chain of cells keeping ids sorted; inserts shift, queries advance a cursor.
// ----------------------------------------------------------------------------
// The result beat lands in the output register the cycle after its input beat.
// Throughput: 1 item per cycle while the result is taken; the whole cell chain
// compares and shifts in the accept cycle, so the next item follows at once.
// Reset (synchronous, active low): set empty, count and cursor zero,
// size_limit 64, output register empty.
module sorted_id_set_intersection_count_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sidc_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sidc_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sidc_pkg::LIMIT_W-1:0]        i_cfg_data
);

    logic [sidc_pkg::LIMIT_W-1:0] r_limit;
    logic [sidc_pkg::FILL_W-1:0]  r_fill;
    logic [sidc_pkg::FILL_W-1:0]  n_fill;
    logic [sidc_pkg::COUNT_W-1:0] r_count;
    logic [sidc_pkg::COUNT_W-1:0] n_count;
    logic                         r_out_valid;
    sidc_pkg::t_out_beat          r_out;
    sidc_pkg::t_out_beat          n_out;

    sidc_pkg::t_bcast             w_bcast;
    sidc_pkg::t_link              w_link [sidc_pkg::SET_DEPTH+1];
    logic [sidc_pkg::SET_DEPTH-1:0] w_hit;

    logic w_accept;
    logic w_is_ins;
    logic w_is_qry;
    logic w_full_now;
    logic w_full_after;
    logic w_drop;
    logic w_match;
    logic [sidc_pkg::COUNT_W-1:0] w_count_after;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_is_ins    = w_accept && (i_in_data.command == sidc_pkg::CMD_INSERT);
    assign w_is_qry    = w_accept && (i_in_data.command == sidc_pkg::CMD_QUERY);

    assign w_full_now = (sidc_pkg::CMP_W'(r_fill) >= sidc_pkg::CMP_W'(r_limit)) ||
                        (sidc_pkg::CMP_W'(r_fill) == sidc_pkg::DEPTH_CMP);
    assign w_drop     = w_is_ins && w_full_now;

    assign w_bcast.ins_en  = w_is_ins && !w_full_now;
    assign w_bcast.qry_en  = w_is_qry;
    assign w_bcast.cur_clr = i_in_data.last_of_pattern;
    assign w_bcast.key     = sidc_pkg::id_of(i_in_data.item_id);

    // head of the chain: always valid, never shifts, cursor passed
    assign w_link[0].valid    = 1'b1;
    assign w_link[0].take     = 1'b0;
    assign w_link[0].cur_next = 1'b1;
    assign w_link[0].id       = '0;

    for (genvar g = 0; g < sidc_pkg::SET_DEPTH; g++) begin : g_cell
        sidc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bcast (w_bcast),
            .i_left  (w_link[g]),
            .o_right (w_link[g+1]),
            .o_hit   (w_hit[g])
        );
    end

    assign w_match = |w_hit;

    always_comb begin
        n_fill        = r_fill;
        n_count       = r_count;
        w_count_after = r_count;
        if (w_bcast.ins_en) begin
            n_fill = r_fill + sidc_pkg::FILL_W'(1);
        end
        if (w_is_qry && w_match && (r_count != sidc_pkg::COUNT_MAX)) begin
            w_count_after = r_count + sidc_pkg::COUNT_W'(1);
        end
        if (w_is_qry) begin
            n_count = i_in_data.last_of_pattern ? '0 : w_count_after;
        end
    end

    assign w_full_after = (sidc_pkg::CMP_W'(n_fill) >= sidc_pkg::CMP_W'(r_limit)) ||
                          (sidc_pkg::CMP_W'(n_fill) == sidc_pkg::DEPTH_CMP);

    always_comb begin
        n_out.match_count    = w_count_after;
        n_out.pattern_done   = w_is_qry && i_in_data.last_of_pattern;
        n_out.set_full       = w_full_after;
        n_out.insert_dropped = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= sidc_pkg::LIMIT_RST;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            r_fill  <= n_fill;
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/sidc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_cell - one slot of the sorted id chain
// Holds one id, its valid bit and one bit of the search cursor
// thermometer; shifts right on insert and flags a hit on query.
// ----------------------------------------------------------------------------
module sidc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sidc_pkg::t_bcast  i_bcast,
    input  sidc_pkg::t_link   i_left,
    output sidc_pkg::t_link   o_right,
    output logic              o_hit
);

    logic [sidc_pkg::ID_BITS-1:0] r_id;
    logic                         r_valid;
    logic                         r_cur;

    logic w_lt;
    logic w_gt;
    logic w_eq;
    logic w_take;
    logic w_cur_next;

    assign w_lt       = r_valid && (r_id < i_bcast.key);
    assign w_gt       = r_valid && (r_id > i_bcast.key);
    assign w_eq       = r_valid && (r_id == i_bcast.key);
    assign w_take     = !r_valid || w_gt;
    // cursor lands on the first cell not passed over
    assign w_cur_next = r_cur || w_lt;
    assign o_hit      = w_eq && i_left.cur_next && !w_cur_next;

    assign o_right.valid    = r_valid;
    assign o_right.take     = w_take;
    assign o_right.cur_next = w_cur_next;
    assign o_right.id       = r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cur   <= 1'b0;
        end else begin
            if (i_bcast.ins_en && w_take) begin
                r_valid <= r_valid || i_left.valid;
            end
            if (i_bcast.qry_en) begin
                r_cur <= i_bcast.cur_clr ? 1'b0 : w_cur_next;
            end
        end
    end

    // shift the left neighbor in, or drop the new id here at the boundary
    always_ff @(posedge i_clk) begin
        if (i_bcast.ins_en && w_take) begin
            r_id <= i_left.take ? i_left.id : i_bcast.key;
        end
    end

endmodule

@@ hdl/sidc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_checker - port level checks for the sorted id set block
// Watches the handshakes and result flags of the top level.
// ----------------------------------------------------------------------------
module sidc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sidc_pkg::t_out_beat o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.insert_dropped |-> o_out_data.set_full)
        else $error("dropped insert without full flag");

    a_done_not_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.pattern_done && o_out_data.insert_dropped))
        else $error("one beat both closes a pattern and drops an insert");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted beat gave no result next cycle");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind sorted_id_set_intersection_count_top sidc_checker u_sidc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
